@@ rtl/core/jaos_pkg.sv @@
// ----------------------------------------------------------------------------
// jaos_pkg
// Shared types and constants for the JSON array object splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package jaos_pkg;

    localparam int DEFAULT_MAX_DEPTH   = 64;
    localparam int DEFAULT_OFFSET_BITS = 32;

    localparam int FIFO_DEPTH = 4;

    localparam int OFF_W  = 32;
    localparam int LEN_W  = 32;
    localparam int OBJ_W  = 32;
    localparam int REC_W  = 20;
    localparam int STAT_W = 2;
    localparam int TDATA_W = 120;

    localparam logic [REC_W-1:0] MAX_RECORDS_RESET = 20'd1024;

    localparam logic REG_MAX_RECORDS = 1'b0;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_SYNTAX = 2'd1;
    localparam logic [STAT_W-1:0] ST_NEST   = 2'd2;
    localparam logic [STAT_W-1:0] ST_CAP    = 2'd3;

    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        PH_OPEN,
        PH_ELEM,
        PH_OBJ,
        PH_AFTER,
        PH_DONE,
        PH_ERR_SYNTAX,
        PH_ERR_NEST,
        PH_ERR_CAP
    } phase_t;

    // One queue entry: an optional record followed by an optional summary.
    typedef struct packed {
        logic              rec_valid;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
        logic              sum_valid;
        logic [OBJ_W-1:0]  objects;
        logic [REC_W-1:0]  records;
        logic [STAT_W-1:0] status;
    } evt_t;

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/json_array_object_splitter.sv @@
// ----------------------------------------------------------------------------
// json_array_object_splitter
// Splits a streamed JSON array of objects into per-object offset/length
// records and ends each buffer with a summary item.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle on the input stream (tlast marks the
// last byte of a buffer). Each byte goes through the parser in the cycle it is
// accepted; a byte that closes a top-level object queues a record unless the
// record limit is hit, and the last byte queues a summary (objects seen,
// records sent, status). Results pass the four-entry event queue, then leave
// through a registered output one per cycle while m_tready is high; the queue
// absorbs a byte that yields both a record and a summary, and input stalls
// only when it is full. max_records, set through APB, limits records per
// buffer; the user writes it only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module json_array_object_splitter #(
    parameter int MAX_DEPTH   = jaos_pkg::DEFAULT_MAX_DEPTH,
    parameter int OFFSET_BITS = jaos_pkg::DEFAULT_OFFSET_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,  // [7:0] data_byte
    input  wire logic                          s_tlast,  // end_of_input
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] offset, [63:32] length, [95:64] objects_total,
    // [115:96] records_total, [117:116] status, [119:118] zero
    output logic [jaos_pkg::TDATA_W-1:0]       m_tdata,
    output logic                               m_tuser,  // kind
    output logic                               m_tlast   // last
);

    logic [jaos_pkg::REC_W-1:0] max_records_reg, max_records_next;
    logic                       cfg_write;
    logic                       accept;
    logic                       fifo_ready, fifo_empty, fifo_pop, evt_push;
    jaos_pkg::evt_t             evt, head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == jaos_pkg::REG_MAX_RECORDS);
    assign prdata    = (paddr[2] == jaos_pkg::REG_MAX_RECORDS) ?
                       {{(32 - jaos_pkg::REC_W){1'b0}}, max_records_reg} : 32'd0;

    always_comb
    begin
        max_records_next = cfg_write ? pwdata[jaos_pkg::REC_W-1:0] : max_records_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_records_reg <= jaos_pkg::MAX_RECORDS_RESET;
        else
            max_records_reg <= max_records_next;
    end

    assign s_tready = fifo_ready;
    assign accept   = s_tvalid && s_tready;

    jaos_front #(
        .MAX_DEPTH   (MAX_DEPTH),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (s_tdata),
        .end_of_input (s_tlast),
        .max_records  (max_records_reg),
        .evt          (evt),
        .evt_push     (evt_push)
    );

    jaos_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (evt_push),
        .push_evt (evt),
        .ready    (fifo_ready),
        .pop      (fifo_pop),
        .head     (head),
        .empty    (fifo_empty)
    );

    jaos_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (fifo_empty),
        .pop      (fifo_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/core/jaos_front.sv @@
// ----------------------------------------------------------------------------
// jaos_front
// Byte parser: phase, string/escape state, bracket stack, counters.
// Produces one queue entry for each byte that yields a record or a summary.
// ----------------------------------------------------------------------------
`default_nettype none

module jaos_front #(
    parameter int MAX_DEPTH   = jaos_pkg::DEFAULT_MAX_DEPTH,
    parameter int OFFSET_BITS = jaos_pkg::DEFAULT_OFFSET_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [7:0]                  data_byte,
    input  wire logic                        end_of_input,
    input  wire logic [jaos_pkg::REC_W-1:0]  max_records,
    output jaos_pkg::evt_t                   evt,
    output logic                             evt_push
);

    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int DEP_W = $clog2(MAX_DEPTH + 1);
    localparam int WIDE_W = OFFSET_BITS + jaos_pkg::OFF_W;

    jaos_pkg::phase_t phase_reg, phase_step, phase_next;

    logic                        in_string_reg, in_string_step, in_string_next;
    logic                        esc_reg, esc_step, esc_next;
    logic [DEP_W-1:0]            depth_reg, depth_step, depth_next;
    logic [OFFSET_BITS-1:0]      pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]      start_reg, start_next;
    logic [jaos_pkg::OBJ_W-1:0]  objects_reg, objects_step, objects_next;
    logic [jaos_pkg::REC_W-1:0]  records_reg, records_step, records_next;

    logic                        stack_mem [MAX_DEPTH];
    logic                        top_reg;
    logic                        below_reg;

    logic is_open, is_close, is_lbrace, is_rbrace, is_quote, is_bslash, blank;
    logic in_obj, obj_plain, nest_full;
    logic obj_push, obj_nest_err, obj_mismatch, obj_pop, obj_close;
    logic cap_hit, emit_rec, elem_open, stk_push, stk_pop, push_bit;

    logic [DEP_W-1:0]            rd_wide;
    logic [IDX_W-1:0]            rd_idx;
    logic [OFFSET_BITS-1:0]      len_raw;
    logic [WIDE_W-1:0]           off_wide, len_wide;
    logic [jaos_pkg::STAT_W-1:0] status;

    assign is_lbrace = (data_byte == jaos_pkg::CH_LBRACE);
    assign is_rbrace = (data_byte == jaos_pkg::CH_RBRACE);
    assign is_open   = is_lbrace || (data_byte == jaos_pkg::CH_LBRACK);
    assign is_close  = is_rbrace || (data_byte == jaos_pkg::CH_RBRACK);
    assign is_quote  = (data_byte == jaos_pkg::CH_QUOTE);
    assign is_bslash = (data_byte == jaos_pkg::CH_BSLASH);
    assign blank     = jaos_pkg::is_blank(data_byte);

    assign in_obj       = (phase_reg == jaos_pkg::PH_OBJ);
    assign obj_plain    = in_obj && !in_string_reg;
    assign nest_full    = (depth_reg >= DEP_W'(MAX_DEPTH));
    assign obj_push     = obj_plain && is_open && !nest_full;
    assign obj_nest_err = obj_plain && is_open && nest_full;
    assign obj_mismatch = obj_plain && is_close &&
                          ((depth_reg == '0) || (top_reg != is_rbrace));
    assign obj_pop      = obj_plain && is_close && !obj_mismatch;
    assign obj_close    = obj_pop && (depth_reg == DEP_W'(1));
    assign cap_hit      = (records_reg >= max_records);
    assign emit_rec     = obj_close && !cap_hit;
    assign elem_open    = (phase_reg == jaos_pkg::PH_ELEM) && is_lbrace;

    assign stk_push = accept && (elem_open || obj_push);
    assign stk_pop  = accept && obj_pop;
    assign push_bit = elem_open ? 1'b1 : is_lbrace;

    assign rd_wide = depth_reg - DEP_W'(3);
    assign rd_idx  = rd_wide[IDX_W-1:0];

    // next state
    always_comb
    begin
        phase_step = phase_reg;
        case (phase_reg)
            jaos_pkg::PH_OPEN:
            begin
                if (data_byte == jaos_pkg::CH_LBRACK)
                    phase_step = jaos_pkg::PH_ELEM;
                else if (!blank)
                    phase_step = jaos_pkg::PH_ERR_SYNTAX;
            end
            jaos_pkg::PH_ELEM:
            begin
                if (data_byte == jaos_pkg::CH_RBRACK)
                    phase_step = jaos_pkg::PH_DONE;
                else if (is_lbrace)
                    phase_step = jaos_pkg::PH_OBJ;
                else if (!blank)
                    phase_step = jaos_pkg::PH_ERR_SYNTAX;
            end
            jaos_pkg::PH_OBJ:
            begin
                if (obj_nest_err)
                    phase_step = jaos_pkg::PH_ERR_NEST;
                else if (obj_mismatch)
                    phase_step = jaos_pkg::PH_ERR_SYNTAX;
                else if (obj_close)
                    phase_step = cap_hit ? jaos_pkg::PH_ERR_CAP : jaos_pkg::PH_AFTER;
            end
            jaos_pkg::PH_AFTER:
            begin
                if (data_byte == jaos_pkg::CH_COMMA)
                    phase_step = jaos_pkg::PH_ELEM;
                else if (data_byte == jaos_pkg::CH_RBRACK)
                    phase_step = jaos_pkg::PH_DONE;
                else if (!blank)
                    phase_step = jaos_pkg::PH_ERR_SYNTAX;
            end
            default:
            begin
                phase_step = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        in_string_step = in_string_reg;
        esc_step       = esc_reg;
        depth_step     = depth_reg;
        objects_step   = objects_reg;
        records_step   = records_reg;
        if (elem_open)
        begin
            in_string_step = 1'b0;
            esc_step       = 1'b0;
            depth_step     = DEP_W'(1);
        end
        else if (in_obj)
        begin
            if (in_string_reg)
            begin
                if (esc_reg)
                    esc_step = 1'b0;
                else if (is_bslash)
                    esc_step = 1'b1;
                else if (is_quote)
                    in_string_step = 1'b0;
            end
            else if (is_quote)
            begin
                in_string_step = 1'b1;
            end
            if (obj_push)
                depth_step = depth_reg + DEP_W'(1);
            else if (obj_pop)
                depth_step = depth_reg - DEP_W'(1);
            if (obj_close)
                objects_step = objects_reg + jaos_pkg::OBJ_W'(1);
            if (emit_rec)
                records_step = records_reg + jaos_pkg::REC_W'(1);
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        in_string_next = in_string_reg;
        esc_next       = esc_reg;
        depth_next     = depth_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        objects_next   = objects_reg;
        records_next   = records_reg;
        if (accept)
        begin
            if (elem_open)
                start_next = pos_reg;
            if (end_of_input)
            begin
                phase_next     = jaos_pkg::PH_OPEN;
                in_string_next = 1'b0;
                esc_next       = 1'b0;
                depth_next     = '0;
                pos_next       = '0;
                objects_next   = '0;
                records_next   = '0;
            end
            else
            begin
                phase_next     = phase_step;
                in_string_next = in_string_step;
                esc_next       = esc_step;
                depth_next     = depth_step;
                pos_next       = pos_reg + OFFSET_BITS'(1);
                objects_next   = objects_step;
                records_next   = records_step;
            end
        end
    end

    // outputs
    always_comb
    begin
        case (phase_step)
            jaos_pkg::PH_DONE:       status = jaos_pkg::ST_OK;
            jaos_pkg::PH_ERR_NEST:   status = jaos_pkg::ST_NEST;
            jaos_pkg::PH_ERR_CAP:    status = jaos_pkg::ST_CAP;
            default:                 status = jaos_pkg::ST_SYNTAX;
        endcase
    end

    assign len_raw  = pos_reg - start_reg + OFFSET_BITS'(1);
    assign off_wide = {{jaos_pkg::OFF_W{1'b0}}, start_reg};
    assign len_wide = {{jaos_pkg::OFF_W{1'b0}}, len_raw};

    always_comb
    begin
        evt.rec_valid = emit_rec;
        evt.offset    = off_wide[jaos_pkg::OFF_W-1:0];
        evt.length    = len_wide[jaos_pkg::LEN_W-1:0];
        evt.sum_valid = end_of_input;
        evt.objects   = objects_step;
        evt.records   = records_step;
        evt.status    = status;
        evt_push      = accept && (emit_rec || end_of_input);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= jaos_pkg::PH_OPEN;
            in_string_reg <= 1'b0;
            esc_reg       <= 1'b0;
            depth_reg     <= '0;
            pos_reg       <= '0;
            objects_reg   <= '0;
            records_reg   <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            in_string_reg <= in_string_next;
            esc_reg       <= esc_next;
            depth_reg     <= depth_next;
            pos_reg       <= pos_next;
            objects_reg   <= objects_next;
            records_reg   <= records_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
    end

    // bracket stack: full copy in memory, top two entries cached
    always_ff @(posedge clk)
    begin
        if (stk_push)
            stack_mem[depth_reg[IDX_W-1:0]] <= push_bit;
    end

    always_ff @(posedge clk)
    begin
        if (stk_push)
        begin
            top_reg   <= push_bit;
            below_reg <= top_reg;
        end
        else if (stk_pop)
        begin
            top_reg   <= below_reg;
            below_reg <= stack_mem[rd_idx];
        end
    end

`ifndef SYNTH
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEP_W'(MAX_DEPTH))
        else $error("nesting depth above limit");

    a_obj_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == jaos_pkg::PH_OBJ) |-> (depth_reg != '0))
        else $error("inside object with empty stack");

    a_eoi_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_input) |=> (phase_reg == jaos_pkg::PH_OPEN &&
                                       depth_reg == '0 && pos_reg == '0))
        else $error("state not cleared after end of input");
`endif

endmodule

`default_nettype wire

@@ rtl/core/jaos_fifo.sv @@
// ----------------------------------------------------------------------------
// jaos_fifo
// Short queue of parser events between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module jaos_fifo (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  jaos_pkg::evt_t  push_evt,
    output logic            ready,
    input  wire logic       pop,
    output jaos_pkg::evt_t  head,
    output logic            empty
);

    localparam int PTR_W = $clog2(jaos_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(jaos_pkg::FIFO_DEPTH + 1);

    jaos_pkg::evt_t     entries_reg [jaos_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign ready = (count_reg != CNT_W'(jaos_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_evt;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ready)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ rtl/core/jaos_back.sv @@
// ----------------------------------------------------------------------------
// jaos_back
// Turns queue entries into result items: record first, then summary.
// ----------------------------------------------------------------------------
`default_nettype none

module jaos_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  jaos_pkg::evt_t                     head,
    input  wire logic                          empty,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [jaos_pkg::TDATA_W-1:0]       m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    logic                          out_valid_reg, out_valid_next;
    logic                          second_reg, second_next;
    logic                          kind_reg;
    logic [jaos_pkg::OFF_W-1:0]    offset_reg;
    logic [jaos_pkg::LEN_W-1:0]    length_reg;
    logic [jaos_pkg::OBJ_W-1:0]    objects_reg;
    logic [jaos_pkg::REC_W-1:0]    records_reg;
    logic [jaos_pkg::STAT_W-1:0]   status_reg;

    logic load, take, piece_rec;

    assign load      = !out_valid_reg || m_tready;
    assign take      = load && !empty;
    assign piece_rec = head.rec_valid && !second_reg;
    assign pop       = take && (!piece_rec || !head.sum_valid);

    always_comb
    begin
        out_valid_next = load ? !empty : out_valid_reg;
        second_next    = take ? (piece_rec && head.sum_valid) : second_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (piece_rec)
            begin
                kind_reg    <= jaos_pkg::KIND_RECORD;
                offset_reg  <= head.offset;
                length_reg  <= head.length;
                objects_reg <= '0;
                records_reg <= '0;
                status_reg  <= jaos_pkg::ST_OK;
            end
            else
            begin
                kind_reg    <= jaos_pkg::KIND_SUMMARY;
                offset_reg  <= '0;
                length_reg  <= '0;
                objects_reg <= head.objects;
                records_reg <= head.records;
                status_reg  <= head.status;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = (kind_reg == jaos_pkg::KIND_SUMMARY);
    assign m_tdata  = {2'b00, status_reg, records_reg, objects_reg, length_reg, offset_reg};

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Regression bench for json_array_object_splitter.
// ----------------------------------------------------------------------------
// Streams JSON buffers into the block one byte per request. Short hand-written
// buffers come first, then random arrays of objects (strings with escapes,
// nested brackets, deep nesting) with some buffers broken or replaced by
// noise. A scoreboard in the bench tracks the parse state of every accepted
// byte and predicts the object records and end summaries. Each result leaves
// the block and is checked field by field against the oldest prediction.
// max_records is rewritten between phases while the block is idle. Both
// stream sides stall at random.
// ----------------------------------------------------------------------------

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_NEST = jaos_pkg::DEFAULT_MAX_DEPTH;
    localparam int PHASE_BYTES = 80;
    localparam logic [2:0] ADDR_MAX_RECORDS = {jaos_pkg::REG_MAX_RECORDS, 2'b00};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       calm_send;
        logic       calm_take;
    } stream_byte_t;

    typedef struct packed {
        logic                        kind;
        logic [jaos_pkg::OFF_W-1:0]  offset;
        logic [jaos_pkg::LEN_W-1:0]  length;
        logic [jaos_pkg::OBJ_W-1:0]  objects;
        logic [jaos_pkg::REC_W-1:0]  records;
        logic [jaos_pkg::STAT_W-1:0] status;
        logic                        last;
    } split_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata = '0;   // [7:0] data_byte
    logic                          s_tlast = 1'b0; // end_of_input
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // [31:0] offset, [63:32] length, [95:64] objects_total,
    // [115:96] records_total, [117:116] status, [119:118] zero
    logic [jaos_pkg::TDATA_W-1:0]  m_tdata;
    logic                          m_tuser;        // kind
    logic                          m_tlast;        // last

    stream_byte_t  bytes_to_send[$];
    split_result_t results_due[$];
    logic [7:0]    text_buf[$];

    int errors = 0;
    int cycle_count = 0;
    int bytes_queued = 0;
    int send_gap = 0;
    int take_gap = 0;
    logic calm_take = 1'b0;

    // scoreboard state
    jaos_pkg::phase_t           scan_phase;
    logic                       in_str;
    logic                       esc_pending;
    int                         depth;
    logic [63:0]                open_is_brace;
    logic [jaos_pkg::OFF_W-1:0] byte_pos;
    logic [jaos_pkg::OFF_W-1:0] open_pos;
    logic [jaos_pkg::OBJ_W-1:0] objs_seen;
    logic [jaos_pkg::REC_W-1:0] recs_sent;
    logic [jaos_pkg::REC_W-1:0] cfg_max_records;

    json_array_object_splitter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic blank_byte(input logic [7:0] c);
        case (c)
            jaos_pkg::CH_SPACE, jaos_pkg::CH_TAB,
            jaos_pkg::CH_LF, jaos_pkg::CH_CR: blank_byte = 1'b1;
            default:                          blank_byte = 1'b0;
        endcase
    endfunction

    function automatic int draw_gap(input logic calm);
        if (calm)
            draw_gap = 0;
        else
            draw_gap = $urandom_range(0, 11);
    endfunction

    task automatic clear_tracker();
        scan_phase = jaos_pkg::PH_OPEN;
        in_str = 1'b0;
        esc_pending = 1'b0;
        depth = 0;
        open_is_brace = '0;
        byte_pos = '0;
        open_pos = '0;
        objs_seen = '0;
        recs_sent = '0;
    endtask

    // Advances the parse state by one accepted byte and queues the results.
    task automatic track_byte(input logic [7:0] c, input logic eoi);
        split_result_t r;
        case (scan_phase)
            jaos_pkg::PH_OPEN:
            begin
                if (c == jaos_pkg::CH_LBRACK)
                    scan_phase = jaos_pkg::PH_ELEM;
                else if (!blank_byte(c))
                    scan_phase = jaos_pkg::PH_ERR_SYNTAX;
            end
            jaos_pkg::PH_ELEM:
            begin
                if (c == jaos_pkg::CH_RBRACK)
                    scan_phase = jaos_pkg::PH_DONE;
                else if (c == jaos_pkg::CH_LBRACE)
                begin
                    open_pos = byte_pos;
                    in_str = 1'b0;
                    esc_pending = 1'b0;
                    open_is_brace[0] = 1'b1;
                    depth = 1;
                    scan_phase = jaos_pkg::PH_OBJ;
                end
                else if (!blank_byte(c))
                    scan_phase = jaos_pkg::PH_ERR_SYNTAX;
            end
            jaos_pkg::PH_OBJ:
            begin
                if (in_str)
                begin
                    if (esc_pending)
                        esc_pending = 1'b0;
                    else if (c == jaos_pkg::CH_BSLASH)
                        esc_pending = 1'b1;
                    else if (c == jaos_pkg::CH_QUOTE)
                        in_str = 1'b0;
                end
                else if (c == jaos_pkg::CH_QUOTE)
                    in_str = 1'b1;
                else if (c == jaos_pkg::CH_LBRACE || c == jaos_pkg::CH_LBRACK)
                begin
                    if (depth >= MAX_NEST)
                        scan_phase = jaos_pkg::PH_ERR_NEST;
                    else
                    begin
                        open_is_brace[depth] = (c == jaos_pkg::CH_LBRACE);
                        depth++;
                    end
                end
                else if (c == jaos_pkg::CH_RBRACE || c == jaos_pkg::CH_RBRACK)
                begin
                    if (depth == 0 ||
                        open_is_brace[depth-1] != (c == jaos_pkg::CH_RBRACE))
                        scan_phase = jaos_pkg::PH_ERR_SYNTAX;
                    else
                    begin
                        depth--;
                        if (depth == 0)
                        begin
                            objs_seen++;
                            if (recs_sent >= cfg_max_records)
                                scan_phase = jaos_pkg::PH_ERR_CAP;
                            else
                            begin
                                r = '0;
                                r.kind = jaos_pkg::KIND_RECORD;
                                r.offset = open_pos;
                                r.length = byte_pos - open_pos + 1'b1;
                                results_due.push_back(r);
                                recs_sent++;
                                scan_phase = jaos_pkg::PH_AFTER;
                            end
                        end
                    end
                end
            end
            jaos_pkg::PH_AFTER:
            begin
                if (c == jaos_pkg::CH_COMMA)
                    scan_phase = jaos_pkg::PH_ELEM;
                else if (c == jaos_pkg::CH_RBRACK)
                    scan_phase = jaos_pkg::PH_DONE;
                else if (!blank_byte(c))
                    scan_phase = jaos_pkg::PH_ERR_SYNTAX;
            end
            default: ;
        endcase
        byte_pos = byte_pos + 1'b1;
        if (eoi)
        begin
            r = '0;
            r.kind = jaos_pkg::KIND_SUMMARY;
            r.objects = objs_seen;
            r.records = recs_sent;
            r.last = 1'b1;
            case (scan_phase)
                jaos_pkg::PH_DONE:     r.status = jaos_pkg::ST_OK;
                jaos_pkg::PH_ERR_NEST: r.status = jaos_pkg::ST_NEST;
                jaos_pkg::PH_ERR_CAP:  r.status = jaos_pkg::ST_CAP;
                default:               r.status = jaos_pkg::ST_SYNTAX;
            endcase
            results_due.push_back(r);
            clear_tracker();
        end
    endtask

    task automatic flag_error(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        $display("mismatch %s: expected %0h got %0h", field, want, got);
        errors++;
    endtask

    // ------------------------------------------------------------------ driver
    always @(posedge clk)
    begin : feed
        stream_byte_t sb;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                track_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (bytes_to_send.size() != 0)
                begin
                    sb = bytes_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= sb.data;
                    s_tlast <= sb.last;
                    calm_take = sb.calm_take;
                    send_gap <= draw_gap(sb.calm_send);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ----------------------------------------------------------------- monitor
    always @(posedge clk)
    begin : watch
        split_result_t want;
        int nxt;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            take_gap <= 0;
        end
        else
        begin
            nxt = take_gap;
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                    flag_error("unexpected result, kind", '0, 32'(m_tuser));
                else
                begin
                    want = results_due.pop_front();
                    if (m_tuser !== want.kind)
                        flag_error("kind", 32'(want.kind), 32'(m_tuser));
                    if (m_tdata[31:0] !== want.offset)
                        flag_error("offset", want.offset, m_tdata[31:0]);
                    if (m_tdata[63:32] !== want.length)
                        flag_error("length", want.length, m_tdata[63:32]);
                    if (m_tdata[95:64] !== want.objects)
                        flag_error("objects_total", want.objects, m_tdata[95:64]);
                    if (m_tdata[115:96] !== want.records)
                        flag_error("records_total", 32'(want.records),
                                   32'(m_tdata[115:96]));
                    if (m_tdata[117:116] !== want.status)
                        flag_error("status", 32'(want.status), 32'(m_tdata[117:116]));
                    if (m_tdata[119:118] !== 2'b00)
                        flag_error("pad", '0, 32'(m_tdata[119:118]));
                    if (m_tlast !== want.last)
                        flag_error("last", 32'(want.last), 32'(m_tlast));
                end
                nxt = draw_gap(calm_take);
            end
            else if (nxt != 0)
                nxt = nxt - 1;
            take_gap <= nxt;
            m_tready <= (nxt == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("json_array_object_splitter regression: fail");
            $finish;
        end
    end

    // --------------------------------------------------------------- stimulus
    task automatic write_max_records(input logic [jaos_pkg::REC_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MAX_RECORDS;
        pwdata <= {12'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cfg_max_records = val;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (bytes_to_send.size() != 0 || s_tvalid || results_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic add_blank();
        int n;
        n = $urandom_range(0, 2);
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0:       text_buf.push_back(jaos_pkg::CH_SPACE);
                1:       text_buf.push_back(jaos_pkg::CH_TAB);
                2:       text_buf.push_back(jaos_pkg::CH_LF);
                default: text_buf.push_back(jaos_pkg::CH_CR);
            endcase
        end
    endtask

    task automatic add_string();
        int n;
        int i;
        logic [7:0] b;
        text_buf.push_back(jaos_pkg::CH_QUOTE);
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++)
        begin
            b = 8'($urandom);
            if (b == jaos_pkg::CH_QUOTE || $urandom_range(0, 5) == 0)
            begin
                text_buf.push_back(jaos_pkg::CH_BSLASH);
                text_buf.push_back(b);
            end
            else if (b == jaos_pkg::CH_BSLASH)
            begin
                text_buf.push_back(b);
                text_buf.push_back(8'($urandom));
            end
            else
                text_buf.push_back(b);
        end
        text_buf.push_back(jaos_pkg::CH_QUOTE);
    endtask

    // deep > 0 opens exactly that many brackets before closing them all
    task automatic add_object(input int deep);
        bit kinds[$];
        int budget;
        int pick;
        int i;
        logic [7:0] b;
        text_buf.push_back(jaos_pkg::CH_LBRACE);
        kinds.push_back(1'b1);
        if (deep > 0)
        begin
            for (i = 1; i < deep; i++)
            begin
                kinds.push_back(1'($urandom_range(0, 1)));
                text_buf.push_back(kinds[$] ? jaos_pkg::CH_LBRACE : jaos_pkg::CH_LBRACK);
            end
        end
        else
        begin
            budget = $urandom_range(0, 14);
            while (budget > 0 && kinds.size() > 0)
            begin
                budget--;
                pick = $urandom_range(0, 9);
                if (pick < 2 && kinds.size() < 8)
                begin
                    kinds.push_back(1'($urandom_range(0, 1)));
                    text_buf.push_back(kinds[$] ? jaos_pkg::CH_LBRACE :
                                                  jaos_pkg::CH_LBRACK);
                end
                else if (pick == 2 && kinds.size() > 1)
                    text_buf.push_back(kinds.pop_back() ? jaos_pkg::CH_RBRACE :
                                                          jaos_pkg::CH_RBRACK);
                else if (pick < 5)
                    add_string();
                else
                begin
                    do
                        b = 8'($urandom);
                    while (b == jaos_pkg::CH_LBRACE || b == jaos_pkg::CH_RBRACE ||
                           b == jaos_pkg::CH_LBRACK || b == jaos_pkg::CH_RBRACK ||
                           b == jaos_pkg::CH_QUOTE || b == jaos_pkg::CH_BSLASH);
                    text_buf.push_back(b);
                end
            end
        end
        while (kinds.size() > 0)
            text_buf.push_back(kinds.pop_back() ? jaos_pkg::CH_RBRACE :
                                                  jaos_pkg::CH_RBRACK);
    endtask

    task automatic build_array();
        int n;
        int i;
        add_blank();
        text_buf.push_back(jaos_pkg::CH_LBRACK);
        n = $urandom_range(0, 5);
        for (i = 0; i < n; i++)
        begin
            add_blank();
            add_object(($urandom_range(0, 19) == 0) ? $urandom_range(62, 66) : 0);
            add_blank();
            if (i != n - 1 || $urandom_range(0, 2) == 0)
                text_buf.push_back(jaos_pkg::CH_COMMA);
        end
        add_blank();
        text_buf.push_back(jaos_pkg::CH_RBRACK);
    endtask

    task automatic finish_buffer();
        stream_byte_t sb;
        int i;
        logic calm_s;
        logic calm_t;
        calm_s = ($urandom_range(0, 3) == 0);
        calm_t = ($urandom_range(0, 3) == 0);
        if (text_buf.size() == 0)
            text_buf.push_back(8'($urandom));
        for (i = 0; i < text_buf.size(); i++)
        begin
            sb.data = text_buf[i];
            sb.last = (i == text_buf.size() - 1);
            sb.calm_send = calm_s;
            sb.calm_take = calm_t;
            bytes_to_send.push_back(sb);
        end
        bytes_queued += text_buf.size();
        text_buf.delete();
    endtask

    task automatic random_buffer();
        int k;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                text_buf.push_back(8'($urandom));
        end
        else
        begin
            build_array();
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        k = $urandom_range(1, text_buf.size());
                        while (text_buf.size() > k)
                            void'(text_buf.pop_back());
                    end
                    1: text_buf.insert($urandom_range(0, text_buf.size() - 1), 8'($urandom));
                    2: text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom);
                    default:
                        repeat ($urandom_range(1, 4))
                            text_buf.push_back(8'($urandom));
                endcase
            end
        end
        finish_buffer();
    endtask

    initial
    begin : run
        logic [jaos_pkg::REC_W-1:0] limits[6];
        int p;
        int phase_end;
        clear_tracker();
        cfg_max_records = jaos_pkg::MAX_RECORDS_RESET;
        limits[0] = 20'd1;
        limits[1] = 20'd2;
        limits[2] = 20'hFFFFF;
        limits[3] = jaos_pkg::REC_W'($urandom_range(1, 20'hFFFFF));
        limits[4] = 20'd3;
        limits[5] = jaos_pkg::MAX_RECORDS_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // hand-written buffers
        add_text(" \t\n[ ]");
        finish_buffer();
        add_text("x");
        finish_buffer();
        add_text("[1]");
        finish_buffer();
        add_text("[{\"k\\\"}{\":[1,{}]},{}, ]");
        finish_buffer();
        add_text("[{}x]");
        finish_buffer();
        add_text("[{]}]");
        finish_buffer();
        add_text("[{}]zz");
        finish_buffer();
        add_text("[{}");
        finish_buffer();
        add_text("[{\"");
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h00);
        add_text("\"}]");
        finish_buffer();
        text_buf.push_back(8'h00);
        finish_buffer();
        // one bracket more than the stack holds
        add_text("[{");
        repeat (MAX_NEST) text_buf.push_back(jaos_pkg::CH_LBRACK);
        text_buf.push_back(jaos_pkg::CH_RBRACK);
        finish_buffer();
        settle();

        for (p = 0; p < 6; p++)
        begin
            write_max_records(limits[p]);
            if (p == 0)
            begin
                add_text("[{},{}]");
                finish_buffer();
            end
            phase_end = bytes_queued + PHASE_BYTES;
            while (bytes_queued < phase_end)
                random_buffer();
            settle();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("json_array_object_splitter regression: pass");
        else
            $display("json_array_object_splitter regression: fail");
        $finish;
    end

endmodule
